/* rtl/bcs_pkg.sv */
// ============================================================================
// bcs_pkg: shared widths, codes and tables for the bias calibrate and scale block
// Field widths of the sample and result beats, register codes and the gyro
// reciprocal table.
// ============================================================================
package bcs_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int RAW_W      = 16;
    localparam int AXES       = 6;
    localparam int AXIS_W     = 3;
    localparam int OFF_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int ACC_OUT_W  = 20;
    localparam int RATE_OUT_W = 21;
    localparam int K_W        = 28;
    localparam int PROD_W     = 47;
    localparam int FRAC_SHIFT = 24;
    localparam int GRAV_W     = 15;
    localparam int CNT_CFG_W  = 16;
    localparam int RANGE_W    = 2;

    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 128;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [AXIS_W-1:0] AX_ACCEL_Z = 3'd2;
    localparam logic [AXIS_W-1:0] AX_GYRO_X  = 3'd3;
    localparam logic [AXIS_W-1:0] AX_LAST    = 3'd5;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_START  = 1'b1;

    localparam logic [GRAV_W-1:0] GRAVITY_RESET = 15'd16384;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (FRAC_SHIFT - 1));

    typedef enum logic [1:0] {
        REG_ACCEL_RANGE = 2'd0,
        REG_GYRO_RANGE  = 2'd1,
        REG_CAL_COUNT   = 2'd2,
        REG_GRAVITY     = 2'd3
    } reg_idx_t;

    // round(2^32 / lsb_per_dps) for each gyro full-scale range
    function automatic logic [K_W-1:0] rate_recip(input logic [RANGE_W-1:0] range);
        logic [K_W-1:0] k;
        unique case (range)
            2'd0: k = 28'd32786010;
            2'd1: k = 28'd65572020;
            2'd2: k = 28'd130944125;
            2'd3: k = 28'd261888250;
        endcase
        return k;
    endfunction

endpackage

/* rtl/imu_bias_calibrate_and_scale.sv */
// ============================================================================
// imu_bias_calibrate_and_scale: six-axis bias calibration and range scaling
// Removes per-axis offsets from raw samples, scales them to g and dps fixed
// point, and learns the offsets as rounded means over a calibration run.
// ============================================================================
// Flow: an accepted sample beat steps through the three accel axes, then the
//   three gyro axes in the serial multiplier, then loads the output register,
//   and waits there while m_tready holds the last beat.
// Pacing: s_tready is low until a sample is loaded out, so the next beat waits;
//   the last sample of a run then runs the bit-serial divider on each axis.
// Reset: synchronous aresetn low clears offsets, sums, run state, loads defaults.
module imu_bias_calibrate_and_scale
    import bcs_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,

    input  logic                s_tvalid,
    output logic                s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type: 0 sample, 1 start calibration
    input  logic                s_tuser,

    output logic                m_tvalid,
    input  logic                m_tready,
    // accel_g_x, accel_g_y, accel_g_z (20 bits each),
    // rate_dps_x, rate_dps_y, rate_dps_z (21 bits each), 5 zero bits
    output logic [M_DATA_W-1:0] m_tdata,
    // calibrating
    output logic                m_tuser
);

    localparam int SUM_W  = RAW_W + COUNT_BITS;
    localparam int DCNT_W = $clog2(SUM_W);
    localparam int MCNT_W = $clog2(DIFF_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_MUL,
        ST_FIN,
        ST_DLOAD,
        ST_DIV
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [AXIS_W-1:0]          ax_reg, ax_next;
    logic [S_DATA_W-1:0]        in_sh_reg, in_sh_next;

    logic signed [OFF_W-1:0]    offset_reg [AXES];
    logic signed [OFF_W-1:0]    offset_next [AXES];
    logic signed [SUM_W-1:0]    sum_reg [AXES];
    logic signed [SUM_W-1:0]    sum_next [AXES];
    logic [COUNT_BITS-1:0]      samples_left_reg, samples_left_next;
    logic [COUNT_BITS-1:0]      div_n_reg, div_n_next;
    logic                       cal_active_reg, cal_active_next;

    logic signed [ACC_OUT_W-1:0]  accel_res_reg [3];
    logic signed [ACC_OUT_W-1:0]  accel_res_next [3];
    logic signed [RATE_OUT_W-1:0] rate_res_reg [3];
    logic signed [RATE_OUT_W-1:0] rate_res_next [3];

    logic [DIFF_W-1:0]          mul_d_reg, mul_d_next;
    logic [PROD_W-1:0]          mul_k_reg, mul_k_next;
    logic [PROD_W-1:0]          mul_acc_reg, mul_acc_next;
    logic [MCNT_W-1:0]          mcnt_reg, mcnt_next;

    logic [SUM_W-1:0]           num_sh_reg, num_sh_next;
    logic [COUNT_BITS-1:0]      rem_reg, rem_next;
    logic                       neg_reg, neg_next;
    logic [DCNT_W-1:0]          dcnt_reg, dcnt_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]        m_tdata_reg, m_tdata_next;
    logic                       m_tuser_reg, m_tuser_next;

    logic [RANGE_W-1:0]         accel_range_reg, accel_range_next;
    logic [RANGE_W-1:0]         gyro_range_reg, gyro_range_next;
    logic [CNT_CFG_W-1:0]       cal_count_reg, cal_count_next;
    logic [GRAV_W-1:0]          gravity_reg, gravity_next;

    // ------------------------------------------------------------------
    // Datapath pieces
    // ------------------------------------------------------------------
    logic                       apb_wr;
    logic                       s_beat;
    logic                       out_free;
    logic [COUNT_BITS-1:0]      start_n;

    logic signed [RAW_W-1:0]    raw_cur;
    logic signed [DIFF_W-1:0]   diff_cur;
    logic signed [ACC_OUT_W:0]  acc_shift;
    logic signed [ACC_OUT_W-1:0] accel_sat;

    logic [PROD_W-1:0]          pp;
    logic signed [PROD_W-FRAC_SHIFT-1:0] rate_full;
    logic signed [RATE_OUT_W-1:0] rate_sat;
    logic [1:0]                 rate_idx;

    logic [SUM_W:0]             div_num;
    logic [COUNT_BITS:0]        trial_hi;
    logic [COUNT_BITS+1:0]      trial;
    logic                       qbit;
    logic [SUM_W-1:0]           quot;
    logic [SUM_W-1:0]           off_full;
    logic [OFF_W-1:0]           off_new;

    assign pready   = 1'b1;
    assign apb_wr   = psel && penable && pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign start_n  = COUNT_BITS'(cal_count_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Read back the configuration registers
    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_ACCEL_RANGE: prdata = APB_DW'(accel_range_reg);
            REG_GYRO_RANGE:  prdata = APB_DW'(gyro_range_reg);
            REG_CAL_COUNT:   prdata = APB_DW'(cal_count_reg);
            REG_GRAVITY:     prdata = APB_DW'(gravity_reg);
        endcase
    end

    // Current axis: lowest word of the input shift register against its offset
    assign raw_cur  = in_sh_reg[RAW_W-1:0];
    assign diff_cur = DIFF_W'(raw_cur) - DIFF_W'(offset_reg[ax_reg]);

    // Accel: shift by the range, clamp to the 20-bit field
    assign acc_shift = (ACC_OUT_W + 1)'(diff_cur) <<< accel_range_reg;
    always_comb begin
        if (acc_shift[ACC_OUT_W] != acc_shift[ACC_OUT_W-1]) begin
            accel_sat = acc_shift[ACC_OUT_W] ? {1'b1, {(ACC_OUT_W-1){1'b0}}}
                                             : {1'b0, {(ACC_OUT_W-1){1'b1}}};
        end else begin
            accel_sat = acc_shift[ACC_OUT_W-1:0];
        end
    end

    // Gyro: shift-add multiplier, one bit of the difference per cycle. The
    // sign bit carries negative weight, so its partial product is subtracted.
    assign pp = mul_d_reg[0] ? mul_k_reg : '0;

    // The accumulator starts at one half LSB of the output, so taking the
    // upper bits gives the rounded, floored result.
    assign rate_full = mul_acc_reg[PROD_W-1:FRAC_SHIFT];
    always_comb begin
        if ((rate_full[PROD_W-FRAC_SHIFT-1:RATE_OUT_W-1] != '0) &&
            (rate_full[PROD_W-FRAC_SHIFT-1:RATE_OUT_W-1] != '1)) begin
            rate_sat = rate_full[PROD_W-FRAC_SHIFT-1] ? {1'b1, {(RATE_OUT_W-1){1'b0}}}
                                                      : {1'b0, {(RATE_OUT_W-1){1'b1}}};
        end else begin
            rate_sat = rate_full[RATE_OUT_W-1:0];
        end
    end
    assign rate_idx = 2'(ax_reg - AX_GYRO_X);

    // Divider: the sum plus half the count, divided by the count and floored. A negative numerator is
    // divided as its complement and the quotient complemented back, which
    // gives floor division with a plain unsigned restoring unit.
    assign div_num  = (SUM_W + 1)'(sum_reg[ax_reg]) + (SUM_W + 1)'(div_n_reg >> 1);
    assign trial_hi = {rem_reg, num_sh_reg[SUM_W-1]};
    assign trial    = {1'b0, trial_hi} - {2'b00, div_n_reg};
    assign qbit     = !trial[COUNT_BITS+1];
    assign quot     = {num_sh_reg[SUM_W-2:0], qbit};
    assign off_full = neg_reg ? ~quot : quot;
    always_comb begin
        if (ax_reg == AX_ACCEL_Z) begin
            off_new = off_full[OFF_W-1:0] - OFF_W'(gravity_reg);
        end else begin
            off_new = off_full[OFF_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        state_next        = state_reg;
        ax_next           = ax_reg;
        in_sh_next        = in_sh_reg;
        offset_next       = offset_reg;
        sum_next          = sum_reg;
        samples_left_next = samples_left_reg;
        div_n_next        = div_n_reg;
        cal_active_next   = cal_active_reg;
        accel_res_next    = accel_res_reg;
        rate_res_next     = rate_res_reg;
        mul_d_next        = mul_d_reg;
        mul_k_next        = mul_k_reg;
        mul_acc_next      = mul_acc_reg;
        mcnt_next         = mcnt_reg;
        num_sh_next       = num_sh_reg;
        rem_next          = rem_reg;
        neg_next          = neg_reg;
        dcnt_next         = dcnt_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;
        accel_range_next  = accel_range_reg;
        gyro_range_next   = gyro_range_reg;
        cal_count_next    = cal_count_reg;
        gravity_next      = gravity_reg;

        if (apb_wr) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_ACCEL_RANGE: accel_range_next = pwdata[RANGE_W-1:0];
                REG_GYRO_RANGE:  gyro_range_next  = pwdata[RANGE_W-1:0];
                REG_CAL_COUNT:   cal_count_next   = pwdata[CNT_CFG_W-1:0];
                REG_GRAVITY:     gravity_next     = pwdata[GRAV_W-1:0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    if (s_tuser == REQ_START) begin
                        // Start a run: drop offsets and sums, latch the count
                        for (int i = 0; i < AXES; i++) begin
                            offset_next[i] = '0;
                            sum_next[i]    = '0;
                        end
                        samples_left_next = start_n;
                        div_n_next        = start_n;
                        cal_active_next   = (start_n != '0);
                    end else begin
                        in_sh_next = s_tdata;
                        ax_next    = '0;
                        state_next = ST_AXIS;
                    end
                end
            end

            ST_AXIS: begin
                if (cal_active_reg) begin
                    sum_next[ax_reg] = sum_reg[ax_reg] + SUM_W'(raw_cur);
                end
                in_sh_next = in_sh_reg >> RAW_W;
                if (ax_reg < AX_GYRO_X) begin
                    accel_res_next[ax_reg[1:0]] = accel_sat;
                    ax_next = ax_reg + 1'b1;
                end else begin
                    mul_d_next   = diff_cur;
                    mul_k_next   = PROD_W'(rate_recip(gyro_range_reg));
                    mul_acc_next = ROUND_HALF;
                    mcnt_next    = '0;
                    state_next   = ST_MUL;
                end
            end

            ST_MUL: begin
                if (mcnt_reg == MCNT_W'(DIFF_W)) begin
                    rate_res_next[rate_idx] = rate_sat;
                    ax_next    = ax_reg + 1'b1;
                    state_next = (ax_reg == AX_LAST) ? ST_FIN : ST_AXIS;
                end else begin
                    if (mcnt_reg == MCNT_W'(DIFF_W - 1)) begin
                        mul_acc_next = mul_acc_reg - pp;
                    end else begin
                        mul_acc_next = mul_acc_reg + pp;
                    end
                    mul_d_next = mul_d_reg >> 1;
                    mul_k_next = mul_k_reg << 1;
                    mcnt_next  = mcnt_reg + 1'b1;
                end
            end

            ST_FIN: begin
                // Hold until the output register is free, then load the beat
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b0, rate_res_reg[2], rate_res_reg[1],
                                     rate_res_reg[0], accel_res_reg[2],
                                     accel_res_reg[1], accel_res_reg[0]};
                    m_tuser_next  = cal_active_reg;
                    state_next    = ST_IDLE;
                    if (cal_active_reg) begin
                        samples_left_next = samples_left_reg - 1'b1;
                        if (samples_left_reg == COUNT_BITS'(1)) begin
                            cal_active_next = 1'b0;
                            ax_next         = '0;
                            state_next      = ST_DLOAD;
                        end
                    end
                end
            end

            ST_DLOAD: begin
                neg_next    = div_num[SUM_W];
                num_sh_next = div_num[SUM_W] ? ~div_num[SUM_W-1:0] : div_num[SUM_W-1:0];
                rem_next    = '0;
                dcnt_next   = '0;
                state_next  = ST_DIV;
            end

            ST_DIV: begin
                rem_next    = qbit ? trial[COUNT_BITS-1:0] : trial_hi[COUNT_BITS-1:0];
                num_sh_next = quot;
                dcnt_next   = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(SUM_W - 1)) begin
                    offset_next[ax_reg] = off_new;
                    ax_next    = ax_reg + 1'b1;
                    state_next = (ax_reg == AX_LAST) ? ST_IDLE : ST_DLOAD;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            ax_reg           <= '0;
            for (int i = 0; i < AXES; i++) begin
                offset_reg[i] <= '0;
                sum_reg[i]    <= '0;
            end
            samples_left_reg <= '0;
            div_n_reg        <= '0;
            cal_active_reg   <= 1'b0;
            mcnt_reg         <= '0;
            dcnt_reg         <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            m_tuser_reg      <= 1'b0;
            accel_range_reg  <= '0;
            gyro_range_reg   <= '0;
            cal_count_reg    <= '0;
            gravity_reg      <= GRAVITY_RESET;
        end else begin
            state_reg        <= state_next;
            ax_reg           <= ax_next;
            offset_reg       <= offset_next;
            sum_reg          <= sum_next;
            samples_left_reg <= samples_left_next;
            div_n_reg        <= div_n_next;
            cal_active_reg   <= cal_active_next;
            mcnt_reg         <= mcnt_next;
            dcnt_reg         <= dcnt_next;
            m_tvalid_reg     <= m_tvalid_next;
            m_tdata_reg      <= m_tdata_next;
            m_tuser_reg      <= m_tuser_next;
            accel_range_reg  <= accel_range_next;
            gyro_range_reg   <= gyro_range_next;
            cal_count_reg    <= cal_count_next;
            gravity_reg      <= gravity_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge aclk) begin
        in_sh_reg      <= in_sh_next;
        accel_res_reg  <= accel_res_next;
        rate_res_reg   <= rate_res_next;
        mul_d_reg      <= mul_d_next;
        mul_k_reg      <= mul_k_next;
        mul_acc_reg    <= mul_acc_next;
        num_sh_reg     <= num_sh_next;
        rem_reg        <= rem_next;
        neg_reg        <= neg_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_active_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_active_reg |-> (samples_left_reg != '0))
        else $error("run active with no samples left");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < div_n_reg))
        else $error("divider remainder not below divisor");

    a_divide_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DLOAD) || (state_reg == ST_DIV)) |-> !cal_active_reg)
        else $error("offset divide while run still active");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == REQ_START)) |=>
        ((offset_reg[0] == '0) && (offset_reg[2] == '0) && (sum_reg[5] == '0)))
        else $error("start beat did not clear offsets and sums");

    a_mul_gyro_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (ax_reg >= AX_GYRO_X))
        else $error("multiplier running on an accel axis");

endmodule
